// File: src/i128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i128_pkg: shared types and constants of the 128-bit integer ALU
// Operation codes, datapath step codes and the sequencer control bundle.
// ----------------------------------------------------------------------------
package i128_pkg;

   localparam int unsigned WORD_W = 128;
   localparam int unsigned HALF_W = 64;
   localparam int unsigned CNT_W  = 7;
   localparam int unsigned SH_W   = 7;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0,
      CMD_SUB = 4'd1,
      CMD_MUL = 4'd2,
      CMD_DIV = 4'd3,
      CMD_AND = 4'd4,
      CMD_OR  = 4'd5,
      CMD_XOR = 4'd6,
      CMD_NOT = 4'd7,
      CMD_SHL = 4'd8,
      CMD_SAR = 4'd9,
      CMD_SHR = 4'd10,
      CMD_ROL = 4'd11,
      CMD_ROR = 4'd12
   } cmd_type;

   typedef enum logic [2:0] {
      STEP_IDLE = 3'd0,
      STEP_EXEC = 3'd1,
      STEP_NEGA = 3'd2,
      STEP_NEGB = 3'd3,
      STEP_MUL  = 3'd4,
      STEP_DIV  = 3'd5,
      STEP_FIX  = 3'd6
   } step_type;

   typedef struct packed {
      step_type step;
      logic     last;
   } ctrl_type;

endpackage : i128_pkg
`default_nettype wire

// File: src/int128_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Logic, shift, add and sub give their result from the exec step; mul runs
// one shift-add per bit on the shared adder; div runs two negations, one
// restoring step per bit and one sign fix on the same adder.
// One item at a time; busy holds until the result and drops as the strobe rises.
// Synchronous reset clears the sequencer and the strobe; no clearing pass.
// The receiver takes rsp_valid as issued and cannot stall.
// ----------------------------------------------------------------------------
// int128_alu: 128-bit two's complement integer ALU
// Add, subtract, multiply, signed divide, bitwise, shift and rotate on
// 128-bit operands, built around one shared 128-bit adder.
// ----------------------------------------------------------------------------
module int128_alu
   import i128_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [3:0]          req_cmd,
   input  wire logic [HALF_W-1:0]   req_a_hi,
   input  wire logic [HALF_W-1:0]   req_a_lo,
   input  wire logic [HALF_W-1:0]   req_b_hi,
   input  wire logic [HALF_W-1:0]   req_b_lo,
   input  wire logic [SH_W-1:0]     req_shift_amount,
   output logic                     rsp_valid,
   output logic      [HALF_W-1:0]   rsp_y_hi,
   output logic      [HALF_W-1:0]   rsp_y_lo
);

   ctrl_type          ctrl;
   cmd_type           cmd_ff, cmd_in;
   logic [WORD_W-1:0] opa_ff, opa_in;
   logic [WORD_W-1:0] opb_ff, opb_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic              negq_ff, negq_in;
   logic              zero_ff, zero_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic              valid_ff, valid_in;

   logic [WORD_W-1:0] add_x, add_y, add_sum, logic_y, rem_shift;
   logic              add_inv, add_carry;

   i128_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd_ff),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   i128_adder u_adder (
      .x     (add_x),
      .y     (add_y),
      .inv   (add_inv),
      .sum   (add_sum),
      .carry (add_carry)
   );

   i128_logic u_logic (
      .cmd (cmd_ff),
      .a   (opa_ff),
      .b   (opb_ff),
      .sh  (sh_ff),
      .y   (logic_y)
   );

   assign rem_shift = {acc_ff[WORD_W-2:0], opa_ff[WORD_W-1]};

   always_comb begin
      add_x   = {WORD_W{1'b0}};
      add_y   = opa_ff;
      add_inv = 1'b0;
      case (ctrl.step)
         STEP_EXEC: begin
            add_x   = opa_ff;
            add_y   = opb_ff;
            add_inv = (cmd_ff == CMD_SUB);
         end
         STEP_NEGA: begin
            add_y   = opa_ff;
            add_inv = opa_ff[WORD_W-1];
         end
         STEP_NEGB: begin
            add_y   = opb_ff;
            add_inv = opb_ff[WORD_W-1];
         end
         STEP_MUL: begin
            add_x = acc_ff;
            add_y = opb_ff[0] ? opa_ff : {WORD_W{1'b0}};
         end
         STEP_DIV: begin
            add_x   = rem_shift;
            add_y   = opb_ff;
            add_inv = 1'b1;
         end
         STEP_FIX: begin
            add_y   = opa_ff;
            add_inv = negq_ff;
         end
         default: begin
            add_y = opa_ff;
         end
      endcase
   end

   always_comb begin
      cmd_in   = cmd_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      negq_in  = negq_ff;
      zero_in  = zero_ff;
      y_in     = y_ff;
      valid_in = 1'b0;
      case (ctrl.step)
         STEP_IDLE: begin
            if (start) begin
               cmd_in = cmd_type'(req_cmd);
               opa_in = {req_a_hi, req_a_lo};
               opb_in = {req_b_hi, req_b_lo};
               sh_in  = req_shift_amount;
            end
         end
         STEP_EXEC: begin
            negq_in = opa_ff[WORD_W-1] ^ opb_ff[WORD_W-1];
            zero_in = (opa_ff == {WORD_W{1'b0}}) || (opb_ff == {WORD_W{1'b0}});
            acc_in  = {WORD_W{1'b0}};
            if (cmd_ff inside {CMD_ADD, CMD_SUB}) begin
               y_in     = add_sum;
               valid_in = 1'b1;
            end else if (!(cmd_ff inside {CMD_MUL, CMD_DIV})) begin
               y_in     = logic_y;
               valid_in = 1'b1;
            end
         end
         STEP_NEGA: begin
            opa_in = add_sum;
         end
         STEP_NEGB: begin
            opb_in = add_sum;
         end
         STEP_MUL: begin
            acc_in = add_sum;
            opa_in = {opa_ff[WORD_W-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[WORD_W-1:1]};
            if (ctrl.last) begin
               y_in     = add_sum;
               valid_in = 1'b1;
            end
         end
         STEP_DIV: begin
            acc_in = add_carry ? add_sum : rem_shift;
            opa_in = {opa_ff[WORD_W-2:0], add_carry};
         end
         STEP_FIX: begin
            y_in     = zero_ff ? {WORD_W{1'b0}} : add_sum;
            valid_in = 1'b1;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      negq_ff <= negq_in;
      zero_ff <= zero_in;
      y_ff    <= y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_y_hi  = y_ff[WORD_W-1:HALF_W];
   assign rsp_y_lo  = y_ff[HALF_W-1:0];

endmodule : int128_alu
`default_nettype wire

// File: src/i128_adder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i128_adder: shared 128-bit add/subtract unit
// Computes x + (y ^ inv) + inv with carry out; serves add, subtract,
// negate, multiply accumulate and division trial subtract.
// ----------------------------------------------------------------------------
module i128_adder
   import i128_pkg::*;
(
   input  wire logic [WORD_W-1:0] x,
   input  wire logic [WORD_W-1:0] y,
   input  wire logic              inv,
   output logic      [WORD_W-1:0] sum,
   output logic                   carry
);

   logic [WORD_W:0] total;

   always_comb begin
      total = {1'b0, x} + {1'b0, y ^ {WORD_W{inv}}} + {{WORD_W{1'b0}}, inv};
      sum   = total[WORD_W-1:0];
      carry = total[WORD_W];
   end

endmodule : i128_adder
`default_nettype wire

// File: src/i128_logic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i128_logic: bitwise and shift unit
// Bitwise operations, shifts and rotates of operand A; zero for other codes.
// ----------------------------------------------------------------------------
module i128_logic
   import i128_pkg::*;
(
   input  wire cmd_type           cmd,
   input  wire logic [WORD_W-1:0] a,
   input  wire logic [WORD_W-1:0] b,
   input  wire logic [SH_W-1:0]   sh,
   output logic      [WORD_W-1:0] y
);

   logic [SH_W-1:0] sh_neg;

   always_comb begin
      sh_neg = {SH_W{1'b0}} - sh;
      case (cmd)
         CMD_AND: y = a & b;
         CMD_OR:  y = a | b;
         CMD_XOR: y = a ^ b;
         CMD_NOT: y = ~a;
         CMD_SHL: y = a << sh;
         CMD_SAR: y = WORD_W'($signed(a) >>> sh);
         CMD_SHR: y = a >> sh;
         CMD_ROL: y = (a << sh) | (a >> sh_neg);
         CMD_ROR: y = (a >> sh) | (a << sh_neg);
         default: y = {WORD_W{1'b0}};
      endcase
   end

endmodule : i128_logic
`default_nettype wire

// File: src/i128_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i128_seq: operation sequencer
// Steps the datapath through decode, operand negation, the per-bit multiply
// or divide loop and the final sign fix.
// ----------------------------------------------------------------------------
module i128_seq
   import i128_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire cmd_type cmd,
   output logic         busy,
   output ctrl_type     ctrl
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_NEGA = 7'b0000100,
      S_NEGB = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_FIX  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last;

   assign last = &cnt_ff;
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = {CNT_W{1'b0}};
      ctrl.last = last;
      ctrl.step = STEP_IDLE;
      case (state_ff)
         S_IDLE: begin
            ctrl.step = STEP_IDLE;
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            ctrl.step = STEP_EXEC;
            if (cmd == CMD_MUL) state_in = S_MUL;
            else if (cmd == CMD_DIV) state_in = S_NEGA;
            else state_in = S_IDLE;
         end
         S_NEGA: begin
            ctrl.step = STEP_NEGA;
            state_in  = S_NEGB;
         end
         S_NEGB: begin
            ctrl.step = STEP_NEGB;
            state_in  = S_DIV;
         end
         S_MUL: begin
            ctrl.step = STEP_MUL;
            cnt_in    = cnt_ff + 1'b1;
            if (last) state_in = S_IDLE;
         end
         S_DIV: begin
            ctrl.step = STEP_DIV;
            cnt_in    = cnt_ff + 1'b1;
            if (last) state_in = S_FIX;
         end
         S_FIX: begin
            ctrl.step = STEP_FIX;
            state_in  = S_IDLE;
         end
         default: begin
            ctrl.step = STEP_IDLE;
            state_in  = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= {CNT_W{1'b0}};
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule : i128_seq
`default_nettype wire

// File: test/int128_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int128_alu_tb: self-checking testbench of the 128-bit integer ALU
// A table of directed items (extremes, every operation, divide corner cases,
// zero shift counts, unused codes) is followed by random items under several
// sender idle phases. The table or an in-bench predictor gives each expected
// result; a checker compares every result strobe, half by half, with the oldest.
// ----------------------------------------------------------------------------
module int128_alu_tb
   import i128_pkg::*;
();

   localparam int unsigned N_DIR          = 26;
   localparam int unsigned N_RAND         = 1625;
   localparam int unsigned GAP_MAX        = 150;
   localparam int unsigned DRAIN_CYCLES   = 140;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   localparam logic [3:0] CMD_SPARE_FIRST = 4'd13;
   localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

   localparam logic [WORD_W-1:0] ZERO     = '0;
   localparam logic [WORD_W-1:0] ONE      = 128'd1;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;
   localparam logic [WORD_W-1:0] MIN_NEG  = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] MAX_POS  = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] PAT_A    = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
   localparam logic [WORD_W-1:0] PAT_B    = 128'hf0e1_d2c3_b4a5_9687_7869_5a4b_3c2d_1e0f;

   typedef struct packed {
      logic [3:0]        cmd;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [SH_W-1:0]   sh;
      logic              known;
      logic [WORD_W-1:0] y;
   } dir_row_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic [3:0]        req_cmd          = '0;
   logic [HALF_W-1:0] req_a_hi         = '0;
   logic [HALF_W-1:0] req_a_lo         = '0;
   logic [HALF_W-1:0] req_b_hi         = '0;
   logic [HALF_W-1:0] req_b_lo         = '0;
   logic [SH_W-1:0]   req_shift_amount = '0;
   logic              busy;
   logic              rsp_valid;
   logic [HALF_W-1:0] rsp_y_hi;
   logic [HALF_W-1:0] rsp_y_lo;

   logic [WORD_W-1:0] expected_y [$];
   int unsigned       n_mismatch   = 0;
   int unsigned       quiet_cycles = 0;
   dir_row_type       dir_tbl [N_DIR];
   int unsigned       idle_by_phase [4] = '{0, 64, 0, 13};

   int128_alu u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_a_hi         (req_a_hi),
      .req_a_lo         (req_a_lo),
      .req_b_hi         (req_b_hi),
      .req_b_lo         (req_b_lo),
      .req_shift_amount (req_shift_amount),
      .rsp_valid        (rsp_valid),
      .rsp_y_hi         (rsp_y_hi),
      .rsp_y_lo         (rsp_y_lo)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] alu_result(input logic [3:0] cmd,
                                                    input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b,
                                                    input logic [SH_W-1:0] sh);
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic [WORD_W-1:0] quo;
      case (cmd)
         CMD_ADD: return a + b;
         CMD_SUB: return a - b;
         CMD_MUL: return a * b;
         CMD_DIV: begin
            if (a == ZERO || b == ZERO) return ZERO;
            mag_a = a[WORD_W-1] ? -a : a;
            mag_b = b[WORD_W-1] ? -b : b;
            quo   = mag_a / mag_b;
            return (a[WORD_W-1] ^ b[WORD_W-1]) ? -quo : quo;
         end
         CMD_AND: return a & b;
         CMD_OR:  return a | b;
         CMD_XOR: return a ^ b;
         CMD_NOT: return ~a;
         CMD_SHL: return a << sh;
         CMD_SAR: return $signed(a) >>> sh;
         CMD_SHR: return a >> sh;
         CMD_ROL: return (sh == 0) ? a : ((a << sh) | (a >> (WORD_W - sh)));
         CMD_ROR: return (sh == 0) ? a : ((a >> sh) | (a << (WORD_W - sh)));
         default: return ZERO;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] rand_operand();
      logic [WORD_W-1:0] v;
      v = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4:    v = v >> $urandom_range(1, WORD_W - 1);
         5:       v = -(v >> $urandom_range(HALF_W, WORD_W - 1));
         6:       v = ONE << $urandom_range(0, WORD_W - 1);
         7:       v = 128'($urandom_range(0, 15));
         default: begin
            case ($urandom_range(0, 4))
               0:       v = ZERO;
               1:       v = ONE;
               2:       v = ALL_ONES;
               3:       v = MIN_NEG;
               default: v = MAX_POS;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_item(input logic [3:0] cmd, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b, input logic [SH_W-1:0] sh,
                            input logic [WORD_W-1:0] y_exp, input int unsigned idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_a_hi         <= a[WORD_W-1:HALF_W];
      req_a_lo         <= a[HALF_W-1:0];
      req_b_hi         <= b[WORD_W-1:HALF_W];
      req_b_lo         <= b[HALF_W-1:0];
      req_shift_amount <= sh;
      do @(posedge clock); while (busy !== 1'b0);
      expected_y = {expected_y, y_exp};
   endtask

   always @(posedge clock) begin
      logic [WORD_W-1:0] y_exp;
      if (!reset && rsp_valid) begin
         if (expected_y.size() == 0) begin
            $display("%0t: result with no item pending: actual %h_%h", $time,
                     rsp_y_hi, rsp_y_lo);
            n_mismatch++;
         end else begin
            y_exp = expected_y.pop_front();
            if (rsp_y_hi !== y_exp[WORD_W-1:HALF_W]) begin
               $display("%0t: y_hi mismatch: expected %h actual %h", $time,
                        y_exp[WORD_W-1:HALF_W], rsp_y_hi);
               n_mismatch++;
            end
            if (rsp_y_lo !== y_exp[HALF_W-1:0]) begin
               $display("%0t: y_lo mismatch: expected %h actual %h", $time,
                        y_exp[HALF_W-1:0], rsp_y_lo);
               n_mismatch++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("int128_alu_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      dir_row_type       row;
      logic [3:0]        cmd;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [SH_W-1:0]   sh;

      dir_tbl = '{
         '{CMD_ADD,         ZERO,     ZERO,     7'd0,   1'b1, ZERO},
         '{CMD_ADD,         ALL_ONES, ONE,      7'd0,   1'b1, ZERO},
         '{CMD_ADD,         MAX_POS,  ONE,      7'd0,   1'b1, MIN_NEG},
         '{CMD_SUB,         ZERO,     ONE,      7'd0,   1'b1, ALL_ONES},
         '{CMD_SUB,         MIN_NEG,  ONE,      7'd0,   1'b1, MAX_POS},
         '{CMD_MUL,         ALL_ONES, ALL_ONES, 7'd0,   1'b1, ONE},
         '{CMD_MUL,         PAT_A,    PAT_B,    7'd0,   1'b0, ZERO},
         '{CMD_DIV,         ZERO,     PAT_B,    7'd0,   1'b1, ZERO},
         '{CMD_DIV,         PAT_A,    ZERO,     7'd0,   1'b1, ZERO},
         '{CMD_DIV,         MIN_NEG,  ALL_ONES, 7'd0,   1'b1, MIN_NEG},
         '{CMD_DIV,         MIN_NEG,  ONE,      7'd0,   1'b1, MIN_NEG},
         '{CMD_DIV,         -128'd7,  128'd2,   7'd0,   1'b1, -128'd3},
         '{CMD_DIV,         MAX_POS,  MIN_NEG,  7'd0,   1'b1, ZERO},
         '{CMD_DIV,         PAT_B,    PAT_A,    7'd0,   1'b0, ZERO},
         '{CMD_AND,         ALL_ONES, PAT_B,    7'd0,   1'b1, PAT_B},
         '{CMD_OR,          ZERO,     PAT_A,    7'd0,   1'b1, PAT_A},
         '{CMD_XOR,         PAT_A,    PAT_A,    7'd0,   1'b1, ZERO},
         '{CMD_NOT,         ZERO,     PAT_B,    7'd0,   1'b1, ALL_ONES},
         '{CMD_SHL,         PAT_A,    ZERO,     7'd0,   1'b1, PAT_A},
         '{CMD_SHL,         ONE,      ZERO,     7'd127, 1'b1, MIN_NEG},
         '{CMD_SAR,         MIN_NEG,  ZERO,     7'd127, 1'b1, ALL_ONES},
         '{CMD_SHR,         MIN_NEG,  ZERO,     7'd127, 1'b1, ONE},
         '{CMD_ROL,         MIN_NEG,  ZERO,     7'd1,   1'b1, ONE},
         '{CMD_ROR,         ONE,      ZERO,     7'd1,   1'b1, MIN_NEG},
         '{CMD_SPARE_FIRST, PAT_A,    PAT_B,    7'd5,   1'b1, ZERO},
         '{CMD_SPARE_LAST,  ALL_ONES, ALL_ONES, 7'd127, 1'b1, ZERO}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         row = dir_tbl[i];
         send_item(row.cmd, row.a, row.b, row.sh,
                   row.known ? row.y : alu_result(row.cmd, row.a, row.b, row.sh), 0);
      end

      for (int i = 0; i < N_RAND; i++) begin
         if ($urandom_range(0, 19) == 0)
            cmd = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
         else
            cmd = 4'($urandom_range(CMD_ADD, CMD_ROR));
         a  = rand_operand();
         b  = rand_operand();
         sh = SH_W'($urandom_range(0, WORD_W - 1));
         send_item(cmd, a, b, sh, alu_result(cmd, a, b, sh), idle_by_phase[(i * 4) / N_RAND]);
      end
      start <= 1'b0;

      while (expected_y.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_mismatch == 0) begin
         $display("int128_alu_tb: PASS");
      end else begin
         $display("int128_alu_tb: FAIL");
      end
      $finish;
   end

endmodule
